// ===== sv/dmrp_pkg.sv =====
// shared constants, codes and channel types for the dual motor ramp pwm block
package dmrp_pkg;

  localparam int DUTY_BITS = 20;
  localparam int DUTY_W    = 20;
  localparam int MD_W      = (DUTY_BITS < DUTY_W) ? DUTY_BITS : DUTY_W;
  localparam int SPEED_W   = 16;
  localparam int MAG_W     = 15;
  localparam int STEP_W    = 15;
  localparam int Q_SHIFT   = 14;
  localparam int PROD_W    = MAG_W + MD_W;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [SPEED_W-1:0] Q_ONE     = 16'sd16384;
  localparam logic signed [SPEED_W-1:0] Q_NEG_ONE = -16'sd16384;
  localparam logic [MD_W-1:0]           DUTY_SCALE_RST = MD_W'(8191);

  localparam logic [1:0] FUNC_SET  = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_STOP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_SCALE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_LEFT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_RIGHT = 2'd3;

  typedef struct packed {
    logic [1:0]                func;
    logic signed [SPEED_W-1:0] left_target;
    logic signed [SPEED_W-1:0] right_target;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left_forward_duty;
    logic [DUTY_W-1:0] left_reverse_duty;
    logic [DUTY_W-1:0] right_forward_duty;
    logic [DUTY_W-1:0] right_reverse_duty;
  } out_t;

endpackage

// ===== sv/dual_motor_ramp_pwm_top.sv =====
// dual motor speed ramp with h-bridge pwm duty split
// path: a tick or stop request goes through the input register, the ramp register and the output register to out
// throughput: one request per cycle while in_stall is low; set requests give no result
// stages: input register, ramp/state update, multiply into output register
// reset: synchronous active low; speeds and goals clear to zero, ramp_step 0,
// duty scale 8191, inversion off
module dual_motor_ramp_pwm_top import dmrp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  function automatic logic signed [SPEED_W-1:0] clamp_q(input logic signed [SPEED_W-1:0] v);
    logic signed [SPEED_W-1:0] r;
    if (v > Q_ONE) begin
      r = Q_ONE;
    end else if (v < Q_NEG_ONE) begin
      r = Q_NEG_ONE;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic signed [SPEED_W-1:0] ramp_next(
    input logic signed [SPEED_W-1:0] now,
    input logic signed [SPEED_W-1:0] goal,
    input logic [STEP_W-1:0]         step
  );
    logic signed [SPEED_W:0] diff;
    logic [SPEED_W:0]        gap;
    logic [SPEED_W:0]        moved;
    logic signed [SPEED_W-1:0] r;
    diff  = {goal[SPEED_W-1], goal} - {now[SPEED_W-1], now};
    gap   = diff[SPEED_W] ? (~diff + 17'd1) : diff;
    moved = diff[SPEED_W] ? ({now[SPEED_W-1], now} - {2'b00, step})
                          : ({now[SPEED_W-1], now} + {2'b00, step});
    if ((step == '0) || (gap <= {2'b00, step})) begin
      r = goal;
    end else begin
      r = moved[SPEED_W-1:0];
    end
    return r;
  endfunction

  // configuration
  logic [STEP_W-1:0] ramp_step_r;
  logic [MD_W-1:0]   duty_scale_r;
  logic              invert_left_r;
  logic              invert_right_r;

  // motor state
  logic signed [SPEED_W-1:0] left_now_r, left_now_nxt;
  logic signed [SPEED_W-1:0] right_now_r, right_now_nxt;
  logic signed [SPEED_W-1:0] left_goal_r, left_goal_nxt;
  logic signed [SPEED_W-1:0] right_goal_r, right_goal_nxt;

  // pipeline
  logic                      a_vld_r, a_vld_nxt;
  in_t                       a_data_r;
  logic                      b_vld_r, b_vld_nxt;
  logic signed [SPEED_W-1:0] b_left_r, b_left_nxt;
  logic signed [SPEED_W-1:0] b_right_r, b_right_nxt;
  logic                      o_vld_r, o_vld_nxt;
  out_t                      o_data_r, o_data_nxt;

  logic in_take;
  logic a_has_result;
  logic a_go;
  logic b_free;
  logic b_load;
  logic o_adv;
  logic b_go;
  logic signed [SPEED_W-1:0] left_ramped;
  logic signed [SPEED_W-1:0] right_ramped;

  assign o_adv   = !o_vld_r || !out_stall;
  assign b_go    = b_vld_r && o_adv;
  assign b_free  = !b_vld_r || o_adv;

  assign a_has_result = (a_data_r.func == FUNC_TICK) || (a_data_r.func == FUNC_STOP);
  assign a_go         = a_vld_r && (!a_has_result || b_free);
  assign b_load       = a_go && a_has_result;

  assign in_stall = a_vld_r && !a_go;
  assign in_take  = in_valid && !in_stall;

  assign left_ramped  = ramp_next(left_now_r, left_goal_r, ramp_step_r);
  assign right_ramped = ramp_next(right_now_r, right_goal_r, ramp_step_r);

  // state update as the request leaves the input register
  always_comb begin
    left_now_nxt   = left_now_r;
    right_now_nxt  = right_now_r;
    left_goal_nxt  = left_goal_r;
    right_goal_nxt = right_goal_r;
    b_left_nxt     = b_left_r;
    b_right_nxt    = b_right_r;
    if (a_go) begin
      unique case (a_data_r.func)
        FUNC_SET: begin
          left_goal_nxt  = clamp_q(a_data_r.left_target);
          right_goal_nxt = clamp_q(a_data_r.right_target);
        end
        FUNC_TICK: begin
          left_now_nxt  = left_ramped;
          right_now_nxt = right_ramped;
          b_left_nxt    = left_ramped;
          b_right_nxt   = right_ramped;
        end
        FUNC_STOP: begin
          left_now_nxt   = '0;
          right_now_nxt  = '0;
          left_goal_nxt  = '0;
          right_goal_nxt = '0;
          b_left_nxt     = '0;
          b_right_nxt    = '0;
        end
        default: begin
        end
      endcase
    end
  end

  dmrp_bridge u_bridge_left (
    .speed      (b_left_r),
    .invert     (invert_left_r),
    .duty_scale (duty_scale_r),
    .fwd_duty   (o_data_nxt.left_forward_duty),
    .rev_duty   (o_data_nxt.left_reverse_duty)
  );

  dmrp_bridge u_bridge_right (
    .speed      (b_right_r),
    .invert     (invert_right_r),
    .duty_scale (duty_scale_r),
    .fwd_duty   (o_data_nxt.right_forward_duty),
    .rev_duty   (o_data_nxt.right_reverse_duty)
  );

  always_comb begin
    a_vld_nxt = a_vld_r;
    if (in_take) begin
      a_vld_nxt = 1'b1;
    end else if (a_go) begin
      a_vld_nxt = 1'b0;
    end
    b_vld_nxt = b_vld_r;
    if (b_load) begin
      b_vld_nxt = 1'b1;
    end else if (b_go) begin
      b_vld_nxt = 1'b0;
    end
    o_vld_nxt = o_vld_r;
    if (b_go) begin
      o_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      o_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r        <= 1'b0;
      b_vld_r        <= 1'b0;
      o_vld_r        <= 1'b0;
      left_now_r     <= '0;
      right_now_r    <= '0;
      left_goal_r    <= '0;
      right_goal_r   <= '0;
      ramp_step_r    <= '0;
      duty_scale_r   <= DUTY_SCALE_RST;
      invert_left_r  <= 1'b0;
      invert_right_r <= 1'b0;
    end else begin
      a_vld_r      <= a_vld_nxt;
      b_vld_r      <= b_vld_nxt;
      o_vld_r      <= o_vld_nxt;
      left_now_r   <= left_now_nxt;
      right_now_r  <= right_now_nxt;
      left_goal_r  <= left_goal_nxt;
      right_goal_r <= right_goal_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_RAMP_STEP:    ramp_step_r    <= cfg_wdata[STEP_W-1:0];
          CFG_DUTY_SCALE:   duty_scale_r   <= cfg_wdata[MD_W-1:0];
          CFG_INVERT_LEFT:  invert_left_r  <= cfg_wdata[0];
          CFG_INVERT_RIGHT: invert_right_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      a_data_r <= in_data;
    end
    b_left_r  <= b_left_nxt;
    b_right_r <= b_right_nxt;
    if (b_go) begin
      o_data_r <= o_data_nxt;
    end
  end

  assign out_valid = o_vld_r;
  assign out_data  = o_data_r;

endmodule

// ===== sv/dmrp_bridge.sv =====
// h-bridge split of one motor speed into forward and reverse duty counts
module dmrp_bridge import dmrp_pkg::*; (
  input  logic signed [SPEED_W-1:0] speed,
  input  logic                      invert,
  input  logic [MD_W-1:0]           duty_scale,
  output logic [DUTY_W-1:0]         fwd_duty,
  output logic [DUTY_W-1:0]         rev_duty
);

  logic [SPEED_W-1:0] mag_full;
  logic [MAG_W-1:0]   mag;
  logic [PROD_W-1:0]  prod;
  logic [DUTY_W-1:0]  duty;
  logic               drive_rev;

  // speed is within +-1.0, so the magnitude fits in 15 bits
  assign mag_full = speed[SPEED_W-1] ? (~speed + 16'd1) : speed;
  assign mag      = mag_full[MAG_W-1:0];
  assign prod     = PROD_W'(mag) * PROD_W'(duty_scale);
  assign duty     = DUTY_W'(prod[Q_SHIFT +: MD_W]);

  // inversion flips the sign without needing a negate
  assign drive_rev = invert ? ((speed != '0) && !speed[SPEED_W-1]) : speed[SPEED_W-1];

  assign fwd_duty = drive_rev ? '0 : duty;
  assign rev_duty = drive_rev ? duty : '0;

endmodule
